// ===== hw/rtl/tlsf_pkg.sv =====
// Shared codes and sequencer states for the segregated-fit allocator.
package tlsf_pkg;

   // Request operation codes
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // Response status codes
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_IGNORED = 2'd1;
   localparam logic [1:0] STS_OOM     = 2'd2;
   localparam logic [1:0] STS_BAD     = 2'd3;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_A_MAP,
      S_A_SEARCH,
      S_A_HEAD,
      S_A_CHECK,
      S_A_WALK_HEAD,
      S_A_WALK,
      S_A_SPLIT,
      S_A_LINK,
      S_A_OWN,
      S_F_CHECK,
      S_F_NEXT,
      S_F_NMERGE,
      S_F_NLINK,
      S_F_PREV,
      S_F_PREVRD,
      S_F_PMERGE,
      S_F_PLINK,
      S_R_START,
      S_R_PREV,
      S_R_NEXT,
      S_R_NEXTW,
      S_R_SELF,
      S_I_START,
      S_I_HEAD,
      S_I_LINK,
      S_Q_WALK,
      S_DONE
   } state_type;

endpackage

// ===== hw/rtl/two_level_segregated_fit_allocator_top.sv =====
// Two-level segregated-fit allocator: header memory, list heads, bitmaps and sequencer.
//
//  channel | direction | beat contents
//  --------+-----------+---------------------------------------------------
//  req_    | in        | opcode, request_bytes, data_offset
//  rsp_    | out       | status, result_offset, largest_free
//
//  One beat in, one beat out. The header memory has one registered read port
//  and one write port. After reset a clearing pass writes every header and
//  list head; req_ready stays low meanwhile. A finished beat waits in the
//  response register; the next request is taken while it waits.
//  SECOND_LEVELS is taken to be a power of two.
module two_level_segregated_fit_allocator_top #(
   parameter int POOL_BYTES      = 65536,
   parameter int FIRST_LEVELS    = 32,
   parameter int SECOND_LEVELS   = 16,
   parameter int HEADER_BYTES    = 40,
   parameter int MIN_SPLIT_BYTES = 56
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [19:0] req_request_bytes,
   input  logic [15:0] req_data_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_result_offset,
   output logic [16:0] rsp_largest_free
);
   import tlsf_pkg::*;

   localparam int GRANULES = POOL_BYTES / 8;
   localparam int AW       = $clog2(GRANULES);
   localparam int GW       = $clog2(GRANULES + 1);
   localparam int SW       = $clog2(POOL_BYTES) + 2;
   localparam int FW       = $clog2(FIRST_LEVELS);
   localparam int SLB      = $clog2(SECOND_LEVELS);
   localparam int SLW      = (SLB > 0) ? SLB : 1;
   localparam int CLASSES  = FIRST_LEVELS * SECOND_LEVELS;
   localparam int CIW      = $clog2(CLASSES);
   localparam int CLRN     = (GRANULES > CLASSES) ? GRANULES : CLASSES;
   localparam int CLRW     = $clog2(CLRN);
   localparam logic [GW-1:0] NONE = GW'(GRANULES);

   typedef struct packed {
      logic [SW-1:0] size;
      logic          free;
      logic          start;
      logic [GW-1:0] pprev;
      logic [GW-1:0] pnext;
      logic [GW-1:0] fprev;
      logic [GW-1:0] fnext;
   } hdr_type;

   typedef struct packed {
      logic [FW-1:0]  f;
      logic [SLW-1:0] s;
   } map_type;

   // Size to (first level, second level) class
   function automatic map_type map_class(input logic [SW-1:0] size);
      map_type     m;
      int unsigned fl;
      int unsigned nb;
      logic [SW-1:0] q;
      m  = '0;
      fl = 0;
      if (size >= SW'(32)) begin
         for (int i = 0; i < SW; i++) begin
            if (size[i]) fl = i;
         end
         if (fl >= FIRST_LEVELS) fl = FIRST_LEVELS - 1;
         nb = (fl < SLB) ? fl : SLB;
         q  = (size - (SW'(1) << fl)) >> (fl - nb);
         if (q >= SW'(SECOND_LEVELS)) q = SW'(SECOND_LEVELS - 1);
         m.f = FW'(fl);
         m.s = SLW'(q);
      end
      return m;
   endfunction

   function automatic logic [SW-1:0] lower_bound(input logic [FW-1:0] f,
                                                 input logic [SLW-1:0] s);
      int unsigned nb;
      nb = (int'(f) < SLB) ? int'(f) : SLB;
      return (SW'(1) << f) + (SW'(s) << (int'(f) - nb));
   endfunction

   function automatic logic [CIW-1:0] cls_idx(input logic [FW-1:0] f,
                                              input logic [SLW-1:0] s);
      return CIW'(int'(f) * SECOND_LEVELS + int'(s));
   endfunction

   function automatic logic [SLW-1:0] low_sl(input logic [SECOND_LEVELS-1:0] v);
      logic [SLW-1:0] p;
      p = '0;
      for (int i = SECOND_LEVELS - 1; i >= 0; i--) begin
         if (v[i]) p = SLW'(i);
      end
      return p;
   endfunction

   function automatic logic [FW-1:0] low_fl(input logic [FIRST_LEVELS-1:0] v);
      logic [FW-1:0] p;
      p = '0;
      for (int i = FIRST_LEVELS - 1; i >= 0; i--) begin
         if (v[i]) p = FW'(i);
      end
      return p;
   endfunction

   // Header and list-head memories
   hdr_type       hdr_mem [GRANULES];
   logic [GW-1:0] heads_mem [CLASSES];

   hdr_type        hdr_rd_ff;
   logic [GW-1:0]  heads_rd_ff;
   logic           hdr_we;
   logic [AW-1:0]  hdr_waddr;
   hdr_type        hdr_wdata;
   logic [AW-1:0]  hdr_raddr;
   logic           heads_we;
   logic [CIW-1:0] heads_waddr;
   logic [GW-1:0]  heads_wdata;
   logic [CIW-1:0] heads_raddr;

   // Sequencer state
   state_type      state_ff, state_in;
   state_type      ret_ff, ret_in;
   logic [CLRW-1:0] clr_ff, clr_in;
   logic [AW-1:0]  blk_ff, blk_in;
   hdr_type        blk_w_ff, blk_w_in;
   logic [AW-1:0]  sub_ff, sub_in;
   hdr_type        sub_w_ff, sub_w_in;
   logic [AW-1:0]  lnk_ff, lnk_in;
   logic [SW-1:0]  total_ff, total_in;
   logic [FW-1:0]  srch_f_ff, srch_f_in;
   logic [SLW-1:0] srch_s_ff, srch_s_in;
   logic           split_ff, split_in;
   logic [SW-1:0]  best_ff, best_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic [15:0]    res_offset_ff, res_offset_in;
   logic [16:0]    res_largest_ff, res_largest_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [15:0]    rsp_offset_ff, rsp_offset_in;
   logic [16:0]    rsp_largest_ff, rsp_largest_in;
   logic [FIRST_LEVELS-1:0]  flm_ff, flm_in;
   logic [SECOND_LEVELS-1:0] slm_ff [FIRST_LEVELS];
   logic [SECOND_LEVELS-1:0] slm_in [FIRST_LEVELS];

   // Derived views
   map_type                  sub_map, tot_map, wp_map;
   logic [CIW-1:0]           sub_cls, wp_cls;
   logic [FW-1:0]            slm_idx;
   logic [SECOND_LEVELS-1:0] slm_rd, srch_m;
   logic [FIRST_LEVELS-1:0]  flm_m;

   assign sub_map = map_class(sub_w_ff.size);
   assign sub_cls = cls_idx(sub_map.f, sub_map.s);
   assign tot_map = map_class(total_ff);
   assign wp_map  = map_class(SW'(POOL_BYTES));
   assign wp_cls  = cls_idx(wp_map.f, wp_map.s);
   assign slm_idx = (state_ff == S_A_SEARCH) ? srch_f_ff : sub_map.f;
   assign slm_rd  = slm_ff[slm_idx];
   assign srch_m  = slm_rd & ({SECOND_LEVELS{1'b1}} << srch_s_ff);
   assign flm_m   = flm_ff & (({FIRST_LEVELS{1'b1}} << srch_f_ff) << 1);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_offset = rsp_offset_ff;
   assign rsp_largest_free  = rsp_largest_ff;

   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_mem[hdr_waddr] <= hdr_wdata;
      end
      hdr_rd_ff <= hdr_mem[hdr_raddr];
   end

   always_ff @(posedge clock) begin
      if (heads_we) begin
         heads_mem[heads_waddr] <= heads_wdata;
      end
      heads_rd_ff <= heads_mem[heads_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ret_ff       <= S_DONE;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         flm_ff       <= FIRST_LEVELS'(1) << wp_map.f;
         for (int i = 0; i < FIRST_LEVELS; i++) begin
            slm_ff[i] <= (FW'(i) == wp_map.f) ? (SECOND_LEVELS'(1) << wp_map.s) : '0;
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         flm_ff       <= flm_in;
         slm_ff       <= slm_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff         <= blk_in;
      blk_w_ff       <= blk_w_in;
      sub_ff         <= sub_in;
      sub_w_ff       <= sub_w_in;
      lnk_ff         <= lnk_in;
      total_ff       <= total_in;
      srch_f_ff      <= srch_f_in;
      srch_s_ff      <= srch_s_in;
      split_ff       <= split_in;
      best_ff        <= best_in;
      res_status_ff  <= res_status_in;
      res_offset_ff  <= res_offset_in;
      res_largest_ff <= res_largest_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_offset_ff  <= rsp_offset_in;
      rsp_largest_ff <= rsp_largest_in;
   end

   always_comb begin
      hdr_type       w;
      logic [16:0]   dm;
      logic [31:0]   nsum;
      logic [SW-1:0] nb;
      logic [SW-1:0] rem;
      logic [SLW-1:0] s_pick;
      logic [AW+3:0] offs;

      state_in       = state_ff;
      ret_in         = ret_ff;
      clr_in         = clr_ff;
      blk_in         = blk_ff;
      blk_w_in       = blk_w_ff;
      sub_in         = sub_ff;
      sub_w_in       = sub_w_ff;
      lnk_in         = lnk_ff;
      total_in       = total_ff;
      srch_f_in      = srch_f_ff;
      srch_s_in      = srch_s_ff;
      split_in       = split_ff;
      best_in        = best_ff;
      res_status_in  = res_status_ff;
      res_offset_in  = res_offset_ff;
      res_largest_in = res_largest_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_offset_in  = rsp_offset_ff;
      rsp_largest_in = rsp_largest_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      flm_in         = flm_ff;
      slm_in         = slm_ff;
      req_ready      = 1'b0;
      hdr_we         = 1'b0;
      hdr_waddr      = '0;
      hdr_wdata      = hdr_rd_ff;
      hdr_raddr      = '0;
      heads_we       = 1'b0;
      heads_waddr    = '0;
      heads_wdata    = NONE;
      heads_raddr    = '0;
      w              = hdr_rd_ff;
      dm             = 17'(req_data_offset) - 17'(HEADER_BYTES);
      nsum           = 32'(blk_ff) + 32'(total_ff >> 3);
      nb             = best_ff;
      rem            = blk_w_ff.size - total_ff;
      s_pick         = low_sl(srch_m);
      offs           = ((AW+4)'(blk_ff) << 3) + (AW+4)'(HEADER_BYTES);

      case (state_ff)
         S_CLEAR: begin
            // Sweep headers and list heads to their reset contents
            if (32'(clr_ff) < 32'(GRANULES)) begin
               hdr_we          = 1'b1;
               hdr_waddr       = clr_ff[AW-1:0];
               hdr_wdata       = '0;
               hdr_wdata.pprev = NONE;
               hdr_wdata.pnext = NONE;
               hdr_wdata.fprev = NONE;
               hdr_wdata.fnext = NONE;
               if (clr_ff == '0) begin
                  hdr_wdata.size  = SW'(POOL_BYTES);
                  hdr_wdata.free  = 1'b1;
                  hdr_wdata.start = 1'b1;
               end
            end
            if (32'(clr_ff) < 32'(CLASSES)) begin
               heads_we    = 1'b1;
               heads_waddr = clr_ff[CIW-1:0];
               heads_wdata = (clr_ff[CIW-1:0] == wp_cls) ? '0 : NONE;
            end
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == 32'(CLRN - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_status_in  = STS_OK;
               res_offset_in  = '0;
               res_largest_in = '0;
               case (req_opcode)
                  OP_ALLOC: begin
                     total_in = SW'((32'(req_request_bytes) + 32'(HEADER_BYTES) + 32'd7)
                                    & ~32'd7);
                     if (req_request_bytes == '0) begin
                        res_status_in = STS_IGNORED;
                        state_in      = S_DONE;
                     end else if (32'(req_request_bytes) > 32'(POOL_BYTES)) begin
                        res_status_in = STS_OOM;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_A_MAP;
                     end
                  end
                  OP_FREE: begin
                     blk_in = AW'(dm >> 3);
                     if (req_data_offset == '0) begin
                        res_status_in = STS_IGNORED;
                        state_in      = S_DONE;
                     end else if (req_data_offset < 16'(HEADER_BYTES) || dm[2:0] != 3'd0
                                  || (32'(dm) >> 3) >= 32'(GRANULES)) begin
                        res_status_in = STS_BAD;
                        state_in      = S_DONE;
                     end else begin
                        hdr_raddr = AW'(dm >> 3);
                        state_in  = S_F_CHECK;
                     end
                  end
                  OP_QUERY: begin
                     best_in   = '0;
                     hdr_raddr = '0;
                     state_in  = S_Q_WALK;
                  end
                  default: begin
                     res_status_in = STS_IGNORED;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end

         // ---------------- allocate ----------------
         S_A_MAP: begin
            // Start at a class whose every block fits the request; if there is none, walk the top class
            if (total_ff >= SW'(32) && total_ff == lower_bound(tot_map.f, tot_map.s)) begin
               srch_f_in = tot_map.f;
               srch_s_in = tot_map.s;
               state_in  = S_A_SEARCH;
            end else if (int'(tot_map.s) + 1 < SECOND_LEVELS) begin
               srch_f_in = tot_map.f;
               srch_s_in = tot_map.s + 1'b1;
               state_in  = S_A_SEARCH;
            end else if (int'(tot_map.f) + 1 < FIRST_LEVELS) begin
               srch_f_in = tot_map.f + 1'b1;
               srch_s_in = '0;
               state_in  = S_A_SEARCH;
            end else begin
               heads_raddr = CIW'(CLASSES - 1);
               state_in    = S_A_WALK_HEAD;
            end
         end

         S_A_SEARCH: begin
            if (srch_m != '0) begin
               heads_raddr = cls_idx(srch_f_ff, s_pick);
               state_in    = S_A_HEAD;
            end else if (flm_m != '0) begin
               srch_f_in = low_fl(flm_m);
               srch_s_in = '0;
            end else begin
               res_status_in = STS_OOM;
               state_in      = S_DONE;
            end
         end

         S_A_HEAD: begin
            if (heads_rd_ff == NONE) begin
               res_status_in = STS_OOM;
               state_in      = S_DONE;
            end else begin
               blk_in    = heads_rd_ff[AW-1:0];
               hdr_raddr = heads_rd_ff[AW-1:0];
               state_in  = S_A_CHECK;
            end
         end

         S_A_CHECK: begin
            if (hdr_rd_ff.size < total_ff) begin
               res_status_in = STS_OOM;
               state_in      = S_DONE;
            end else begin
               blk_w_in = hdr_rd_ff;
               sub_in   = blk_ff;
               sub_w_in = hdr_rd_ff;
               ret_in   = S_A_SPLIT;
               state_in = S_R_START;
            end
         end

         S_A_WALK_HEAD: begin
            if (heads_rd_ff == NONE) begin
               res_status_in = STS_OOM;
               state_in      = S_DONE;
            end else begin
               blk_in    = heads_rd_ff[AW-1:0];
               hdr_raddr = heads_rd_ff[AW-1:0];
               state_in  = S_A_WALK;
            end
         end

         S_A_WALK: begin
            // Take the first block of the top class that fits
            if (hdr_rd_ff.size >= total_ff) begin
               blk_w_in = hdr_rd_ff;
               sub_in   = blk_ff;
               sub_w_in = hdr_rd_ff;
               ret_in   = S_A_SPLIT;
               state_in = S_R_START;
            end else if (hdr_rd_ff.fnext == NONE) begin
               res_status_in = STS_OOM;
               state_in      = S_DONE;
            end else begin
               blk_in    = hdr_rd_ff.fnext[AW-1:0];
               hdr_raddr = hdr_rd_ff.fnext[AW-1:0];
            end
         end

         S_A_SPLIT: begin
            if (rem >= SW'(MIN_SPLIT_BYTES) && nsum < 32'(GRANULES)) begin
               split_in  = 1'b1;
               w         = '0;
               w.size    = rem;
               w.free    = 1'b1;
               w.start   = 1'b1;
               w.pprev   = GW'(blk_ff);
               w.pnext   = blk_w_ff.pnext;
               w.fprev   = NONE;
               w.fnext   = NONE;
               hdr_we    = 1'b1;
               hdr_waddr = nsum[AW-1:0];
               hdr_wdata = w;
               sub_in    = nsum[AW-1:0];
               sub_w_in  = w;
               if (blk_w_ff.pnext != NONE) begin
                  hdr_raddr = blk_w_ff.pnext[AW-1:0];
                  lnk_in    = blk_w_ff.pnext[AW-1:0];
                  state_in  = S_A_LINK;
               end else begin
                  state_in = S_A_OWN;
               end
            end else begin
               split_in = 1'b0;
               state_in = S_A_OWN;
            end
         end

         S_A_LINK: begin
            w         = hdr_rd_ff;
            w.pprev   = GW'(sub_ff);
            hdr_we    = 1'b1;
            hdr_waddr = lnk_ff;
            hdr_wdata = w;
            state_in  = S_A_OWN;
         end

         S_A_OWN: begin
            w       = blk_w_ff;
            w.free  = 1'b0;
            w.fprev = NONE;
            w.fnext = NONE;
            if (split_ff) begin
               w.size  = total_ff;
               w.pnext = GW'(sub_ff);
            end
            hdr_we        = 1'b1;
            hdr_waddr     = blk_ff;
            hdr_wdata     = w;
            res_offset_in = 16'(offs);
            if (split_ff) begin
               ret_in   = S_DONE;
               state_in = S_I_START;
            end else begin
               state_in = S_DONE;
            end
         end

         // ---------------- free ----------------
         S_F_CHECK: begin
            if (!hdr_rd_ff.start || hdr_rd_ff.free) begin
               res_status_in = STS_BAD;
               state_in      = S_DONE;
            end else begin
               blk_w_in      = hdr_rd_ff;
               blk_w_in.free = 1'b1;
               if (hdr_rd_ff.pnext != NONE) begin
                  hdr_raddr = hdr_rd_ff.pnext[AW-1:0];
                  sub_in    = hdr_rd_ff.pnext[AW-1:0];
                  state_in  = S_F_NEXT;
               end else begin
                  state_in = S_F_PREV;
               end
            end
         end

         S_F_NEXT: begin
            if (hdr_rd_ff.free) begin
               sub_w_in = hdr_rd_ff;
               ret_in   = S_F_NMERGE;
               state_in = S_R_START;
            end else begin
               state_in = S_F_PREV;
            end
         end

         S_F_NMERGE: begin
            // Absorb the next neighbour; its header stops being a block start
            w              = sub_w_ff;
            w.start        = 1'b0;
            hdr_we         = 1'b1;
            hdr_waddr      = sub_ff;
            hdr_wdata      = w;
            blk_w_in.size  = blk_w_ff.size + sub_w_ff.size;
            blk_w_in.pnext = sub_w_ff.pnext;
            if (sub_w_ff.pnext != NONE) begin
               hdr_raddr = sub_w_ff.pnext[AW-1:0];
               lnk_in    = sub_w_ff.pnext[AW-1:0];
               state_in  = S_F_NLINK;
            end else begin
               state_in = S_F_PREV;
            end
         end

         S_F_NLINK: begin
            w         = hdr_rd_ff;
            w.pprev   = GW'(blk_ff);
            hdr_we    = 1'b1;
            hdr_waddr = lnk_ff;
            hdr_wdata = w;
            state_in  = S_F_PREV;
         end

         S_F_PREV: begin
            if (blk_w_ff.pprev != NONE) begin
               hdr_raddr = blk_w_ff.pprev[AW-1:0];
               sub_in    = blk_w_ff.pprev[AW-1:0];
               state_in  = S_F_PREVRD;
            end else begin
               sub_in   = blk_ff;
               sub_w_in = blk_w_ff;
               ret_in   = S_DONE;
               state_in = S_I_START;
            end
         end

         S_F_PREVRD: begin
            if (hdr_rd_ff.free) begin
               sub_w_in = hdr_rd_ff;
               ret_in   = S_F_PMERGE;
               state_in = S_R_START;
            end else begin
               sub_in   = blk_ff;
               sub_w_in = blk_w_ff;
               ret_in   = S_DONE;
               state_in = S_I_START;
            end
         end

         S_F_PMERGE: begin
            // Fold this block into the previous neighbour
            w         = blk_w_ff;
            w.start   = 1'b0;
            hdr_we    = 1'b1;
            hdr_waddr = blk_ff;
            hdr_wdata = w;
            blk_in         = sub_ff;
            blk_w_in       = sub_w_ff;
            blk_w_in.size  = sub_w_ff.size + blk_w_ff.size;
            blk_w_in.pnext = blk_w_ff.pnext;
            sub_w_in       = blk_w_in;
            ret_in         = S_DONE;
            if (blk_w_ff.pnext != NONE) begin
               hdr_raddr = blk_w_ff.pnext[AW-1:0];
               lnk_in    = blk_w_ff.pnext[AW-1:0];
               state_in  = S_F_PLINK;
            end else begin
               state_in = S_I_START;
            end
         end

         S_F_PLINK: begin
            w         = hdr_rd_ff;
            w.pprev   = GW'(blk_ff);
            hdr_we    = 1'b1;
            hdr_waddr = lnk_ff;
            hdr_wdata = w;
            state_in  = S_I_START;
         end

         // ---------------- unlink from free list ----------------
         S_R_START: begin
            if (sub_w_ff.fprev == NONE && sub_w_ff.fnext == NONE) begin
               slm_in[sub_map.f][sub_map.s] = 1'b0;
               if ((slm_rd & ~(SECOND_LEVELS'(1) << sub_map.s)) == '0) begin
                  flm_in[sub_map.f] = 1'b0;
               end
            end
            if (sub_w_ff.fprev == NONE) begin
               heads_we    = 1'b1;
               heads_waddr = sub_cls;
               heads_wdata = sub_w_ff.fnext;
               state_in    = S_R_NEXT;
            end else begin
               hdr_raddr = sub_w_ff.fprev[AW-1:0];
               state_in  = S_R_PREV;
            end
         end

         S_R_PREV: begin
            w         = hdr_rd_ff;
            w.fnext   = sub_w_ff.fnext;
            hdr_we    = 1'b1;
            hdr_waddr = sub_w_ff.fprev[AW-1:0];
            hdr_wdata = w;
            state_in  = S_R_NEXT;
         end

         S_R_NEXT: begin
            if (sub_w_ff.fnext != NONE) begin
               hdr_raddr = sub_w_ff.fnext[AW-1:0];
               state_in  = S_R_NEXTW;
            end else begin
               state_in = S_R_SELF;
            end
         end

         S_R_NEXTW: begin
            w         = hdr_rd_ff;
            w.fprev   = sub_w_ff.fprev;
            hdr_we    = 1'b1;
            hdr_waddr = sub_w_ff.fnext[AW-1:0];
            hdr_wdata = w;
            state_in  = S_R_SELF;
         end

         S_R_SELF: begin
            w         = sub_w_ff;
            w.fprev   = NONE;
            w.fnext   = NONE;
            hdr_we    = 1'b1;
            hdr_waddr = sub_ff;
            hdr_wdata = w;
            sub_w_in  = w;
            state_in  = ret_ff;
         end

         // ---------------- push onto free list ----------------
         S_I_START: begin
            heads_raddr = sub_cls;
            state_in    = S_I_HEAD;
         end

         S_I_HEAD: begin
            w           = sub_w_ff;
            w.fprev     = NONE;
            w.fnext     = heads_rd_ff;
            hdr_we      = 1'b1;
            hdr_waddr   = sub_ff;
            hdr_wdata   = w;
            heads_we    = 1'b1;
            heads_waddr = sub_cls;
            heads_wdata = GW'(sub_ff);
            flm_in[sub_map.f]            = 1'b1;
            slm_in[sub_map.f][sub_map.s] = 1'b1;
            if (heads_rd_ff != NONE) begin
               hdr_raddr = heads_rd_ff[AW-1:0];
               lnk_in    = heads_rd_ff[AW-1:0];
               state_in  = S_I_LINK;
            end else begin
               state_in = ret_ff;
            end
         end

         S_I_LINK: begin
            w         = hdr_rd_ff;
            w.fprev   = GW'(sub_ff);
            hdr_we    = 1'b1;
            hdr_waddr = lnk_ff;
            hdr_wdata = w;
            state_in  = ret_ff;
         end

         // ---------------- query ----------------
         S_Q_WALK: begin
            // Follow the physical chain from granule zero
            if (hdr_rd_ff.start && hdr_rd_ff.free && hdr_rd_ff.size > best_ff) begin
               nb = hdr_rd_ff.size;
            end
            best_in = nb;
            if (hdr_rd_ff.pnext == NONE) begin
               res_largest_in = (nb >= SW'(HEADER_BYTES)) ? 17'(nb - SW'(HEADER_BYTES)) : '0;
               state_in       = S_DONE;
            end else begin
               hdr_raddr = hdr_rd_ff.pnext[AW-1:0];
            end
         end

         S_DONE: begin
            // Hand over once the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_offset_in  = res_offset_ff;
               rsp_largest_in = res_largest_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
